@@ rtl/neighbor_jaccard_similarity_unit_defines.svh @@
// Assertion macros shared by the neighbor Jaccard similarity unit.
`ifndef NEIGHBOR_JACCARD_SIMILARITY_UNIT_DEFINES_SVH
`define NEIGHBOR_JACCARD_SIMILARITY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define NJS_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is high.
`define NJS_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ rtl/njs_pkg.sv @@
// Package with types, constants and helper functions of the Jaccard similarity unit.
package njs_pkg;

  // Graph size: node ids are NODE_W bits wide, so at most ROWS nodes exist.
  localparam int MAX_NODES = 64;
  localparam int NODE_W    = 6;
  localparam int ROWS      = 2 ** NODE_W;
  localparam int NODES     = (MAX_NODES < ROWS) ? MAX_NODES : ROWS;

  // Counts, ratio and divider sizes.
  localparam int CNT_W      = 7;
  localparam int FRAC_W     = 16;
  localparam int Q_W        = 17;
  localparam int DIV_STEPS  = Q_W;
  localparam int DIV_CNT_W  = 5;

  // Command codes.
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } njs_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] common_count;
    logic [CNT_W-1:0] union_count;
    logic [Q_W-1:0]   similarity_q16;
    logic             is_query_result;
  } njs_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ADD_A,
    ST_ADD_B,
    ST_COUNT,
    ST_UNION,
    ST_DIV,
    ST_FINISH
  } njs_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mem_read;
    logic write_a;
    logic write_b;
    logic count;
    logic union_load;
    logic div_step;
    logic out_load;
  } njs_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       out_free;
  } njs_sts_t;

  // Columns that belong to existing nodes.
  function automatic logic [ROWS-1:0] col_mask();
    logic [ROWS-1:0] m;
    for (int i = 0; i < ROWS; i++) begin
      m[i] = (i < NODES);
    end
    return m;
  endfunction

  localparam logic [ROWS-1:0] COL_MASK = col_mask();

  // True when the id names an existing node.
  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    return (int'(n) < NODES);
  endfunction

  // Population count of one byte.
  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

  // Population count of one row, summed over bytes.
  function automatic logic [CNT_W-1:0] pop_row(input logic [ROWS-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < ROWS / 8; i++) begin
      c = c + CNT_W'(pop8(v[i*8 +: 8]));
    end
    return c;
  endfunction

endpackage

@@ rtl/njs_ctrl.sv @@
// Controller state machine that sequences add, clear and query items.
module njs_ctrl
  import njs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output njs_ctl_t ctl,
  input  njs_sts_t sts
);

  njs_state_t           state;
  njs_state_t           state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_CNT_W-1:0] div_cnt_next;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    req_ready    = 1'b0;
    ctl          = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        ctl.mem_read = 1'b1;
        unique case (sts.cmd)
          CMD_ADD:   state_next = ST_ADD_A;
          CMD_QUERY: state_next = ST_COUNT;
          default:   state_next = ST_FINISH;
        endcase
      end
      ST_ADD_A: begin
        ctl.write_a = 1'b1;
        state_next  = ST_ADD_B;
      end
      ST_ADD_B: begin
        ctl.write_b = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_COUNT: begin
        ctl.count  = 1'b1;
        state_next = ST_UNION;
      end
      ST_UNION: begin
        ctl.union_load = 1'b1;
        div_cnt_next   = '0;
        state_next     = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/njs_dp.sv @@
// Datapath: adjacency memory, popcounts, restoring divider and output register.
module njs_dp
  import njs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  njs_req_t req,
  output njs_rsp_t rsp,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  njs_ctl_t ctl,
  output njs_sts_t sts
);

  njs_req_t          req_r;
  logic [ROWS-1:0]   mem [ROWS];
  logic [ROWS-1:0]   row_valid;
  logic [ROWS-1:0]   rd_a;
  logic [ROWS-1:0]   rd_b;
  logic              vld_a;
  logic              vld_b;
  logic [ROWS-1:0]   row_a;
  logic [ROWS-1:0]   row_b;
  logic              add_ok;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [ROWS-1:0]   wr_data;
  logic              clear_rows;
  logic [CNT_W-1:0]  pop_a;
  logic [CNT_W-1:0]  pop_b;
  logic [CNT_W-1:0]  pop_c;
  logic [CNT_W-1:0]  union_r;
  logic [CNT_W-1:0]  rem;
  logic [Q_W-1:0]    dshift;
  logic [Q_W-1:0]    quo;
  logic [CNT_W:0]    rem_sh;
  logic              take;

  // Latch the accepted item.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_r <= req;
    end
  end

  // A row never written since reset or clear reads as its identity row.
  always_comb begin
    row_a = '0;
    row_b = '0;
    if (node_ok(req_r.node_a)) begin
      row_a = (vld_a ? rd_a : (ROWS'(1) << req_r.node_a)) & COL_MASK;
    end
    if (node_ok(req_r.node_b)) begin
      row_b = (vld_b ? rd_b : (ROWS'(1) << req_r.node_b)) & COL_MASK;
    end
  end

  // Edge insertion writes row a, then row b, through one write port.
  assign add_ok     = node_ok(req_r.node_a) && node_ok(req_r.node_b);
  assign wr_en      = (ctl.write_a || ctl.write_b) && add_ok;
  assign wr_addr    = ctl.write_a ? req_r.node_a : req_r.node_b;
  assign wr_data    = ctl.write_a ? (row_a | (ROWS'(1) << req_r.node_b))
                                  : (row_b | (ROWS'(1) << req_r.node_a));
  assign clear_rows = ctl.out_load && (req_r.cmd == CMD_CLEAR);

  // Adjacency memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.mem_read) begin
      rd_a <= mem[req_r.node_a];
      rd_b <= mem[req_r.node_b];
    end
  end

  // Per-row written flags; a clear drops them all at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (clear_rows) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_read) begin
      vld_a <= row_valid[req_r.node_a];
      vld_b <= row_valid[req_r.node_b];
    end
  end

  // Degree and common-neighbor counts.
  always_ff @(posedge clk) begin
    if (ctl.count) begin
      pop_a <= pop_row(row_a);
      pop_b <= pop_row(row_b);
      pop_c <= pop_row(row_a & row_b);
    end
  end

  // Restoring divider: common * 2^16 / union, one quotient bit per step.
  assign rem_sh = {rem, dshift[Q_W-1]};
  assign take   = (rem_sh >= {1'b0, union_r});

  always_ff @(posedge clk) begin
    if (ctl.union_load) begin
      union_r <= CNT_W'({1'b0, pop_a} + {1'b0, pop_b} - {1'b0, pop_c});
      rem     <= pop_c >> 1;
      dshift  <= Q_W'(pop_c[0]) << FRAC_W;
      quo     <= '0;
    end else if (ctl.div_step) begin
      rem    <= take ? CNT_W'(rem_sh - {1'b0, union_r}) : CNT_W'(rem_sh);
      dshift <= dshift << 1;
      quo    <= {quo[Q_W-2:0], take};
    end
  end

  // Output register; non-query items give an all-zero result.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      if (req_r.cmd == CMD_QUERY) begin
        rsp.common_count    <= pop_c;
        rsp.union_count     <= union_r;
        rsp.similarity_q16  <= (union_r == '0) ? '0 : quo;
        rsp.is_query_result <= 1'b1;
      end else begin
        rsp <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Status back to the controller.
  assign sts.cmd      = req_r.cmd;
  assign sts.out_free = !rsp_valid || rsp_ready;

endmodule

@@ rtl/neighbor_jaccard_similarity_unit.sv @@
// Query steps from accept to result: read, count, union, 17 divider steps, then output load.
// Add edge steps: read, write row a, write row b; clear and other codes only read before the output load.
// One item at a time: a new item is accepted only after the last result is loaded into the output register.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst, synchronous) restores the identity graph at once by dropping row flags.
`include "neighbor_jaccard_similarity_unit_defines.svh"

module neighbor_jaccard_similarity_unit
  import njs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  njs_req_t req,
  input  logic     req_valid,
  output logic     req_ready,
  output njs_rsp_t rsp,
  output logic     rsp_valid,
  input  logic     rsp_ready
);

  njs_ctl_t ctl;
  njs_sts_t sts;

  // Sequencer.
  njs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // Storage and arithmetic.
  njs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // Only one item is in work at a time.
  `NJS_ASSERT_NXT(a_one_item, clk, rst, req_valid && req_ready, !req_ready)
  // A query result never has more common members than its union.
  `NJS_ASSERT_IMP(a_common_le_union, clk, rst, rsp_valid && rsp.is_query_result, rsp.common_count <= rsp.union_count)
  // Equal nonempty neighborhoods give a ratio of exactly one.
  `NJS_ASSERT_IMP(a_ratio_one, clk, rst, rsp_valid && rsp.is_query_result && (rsp.union_count != '0) && (rsp.common_count == rsp.union_count), rsp.similarity_q16 == Q_W'(1) << FRAC_W)
  // Results of add, clear and unused codes are all zero.
  `NJS_ASSERT_IMP(a_zero_result, clk, rst, rsp_valid && !rsp.is_query_result, rsp == '0)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the neighbor Jaccard similarity unit.
`timescale 1ns / 100ps

module testbench;
  import njs_pkg::*;

  // Command code that the block leaves unused.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 420;
  localparam int CALM_ITEMS   = 80;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 40;

  // Mirror of the adjacency matrix plus the queue of expected results.
  class jaccard_scoreboard;
    logic [ROWS-1:0] neighbor_rows [ROWS];
    njs_rsp_t        expected_q [$];
    int unsigned     mismatch_count;

    function new();
      mismatch_count = 0;
      reset_graph();
    endfunction

    // Every existing node is its own neighbor, nothing else.
    function void reset_graph();
      for (int i = 0; i < ROWS; i++) begin
        neighbor_rows[i] = (i < NODES) ? (ROWS'(1) << i) : '0;
      end
    endfunction

    // Closed neighborhood of a node; a missing node has an empty one.
    function logic [ROWS-1:0] neighborhood(logic [NODE_W-1:0] node);
      if (int'(node) >= NODES) begin
        return '0;
      end
      return neighbor_rows[node];
    endfunction

    // Apply an accepted item to the graph and queue the result it must cause.
    function void note_request(njs_req_t item);
      njs_rsp_t        result;
      logic [ROWS-1:0] row_a;
      logic [ROWS-1:0] row_b;
      int              shared;
      int              joined;
      longint unsigned ratio;
      result = '0;
      case (item.cmd)
        CMD_ADD: begin
          if (int'(item.node_a) < NODES && int'(item.node_b) < NODES) begin
            neighbor_rows[item.node_a][item.node_b] = 1'b1;
            neighbor_rows[item.node_b][item.node_a] = 1'b1;
          end
        end
        CMD_CLEAR: begin
          reset_graph();
        end
        CMD_QUERY: begin
          row_a  = neighborhood(item.node_a);
          row_b  = neighborhood(item.node_b);
          shared = $countones(row_a & row_b);
          joined = $countones(row_a) + $countones(row_b) - shared;
          ratio  = (joined == 0) ? 0 : (longint'(shared) * 65536) / joined;
          result.common_count    = CNT_W'(shared);
          result.union_count     = CNT_W'(joined);
          result.similarity_q16  = Q_W'(ratio);
          result.is_query_result = 1'b1;
        end
        default: begin
        end
      endcase
      expected_q.push_back(result);
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 100) begin
        $display("%0t mismatch: %s", $realtime, what);
      end
    endtask

    // Compare a delivered result with the oldest expectation.
    task check_response(njs_rsp_t got);
      njs_rsp_t want;
      string    diffs;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %p arrived with no item waiting", got));
        return;
      end
      want  = expected_q.pop_front();
      diffs = "";
      if (got.common_count !== want.common_count) begin
        diffs = {diffs, $sformatf(" common %0d/%0d", got.common_count, want.common_count)};
      end
      if (got.union_count !== want.union_count) begin
        diffs = {diffs, $sformatf(" union %0d/%0d", got.union_count, want.union_count)};
      end
      if (got.similarity_q16 !== want.similarity_q16) begin
        diffs = {diffs, $sformatf(" ratio %0d/%0d", got.similarity_q16,
                                  want.similarity_q16)};
      end
      if (got.is_query_result !== want.is_query_result) begin
        diffs = {diffs, $sformatf(" query flag %0b/%0b", got.is_query_result,
                                  want.is_query_result)};
      end
      if (diffs != "") begin
        report_mismatch({"got/want:", diffs});
      end
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst;
  njs_req_t req;
  logic     req_valid;
  logic     req_ready;
  njs_rsp_t rsp;
  logic     rsp_valid;
  logic     rsp_ready;

  jaccard_scoreboard board = new();
  bit                calm  = 1'b0;
  int                idle_cycles = 0;

  neighbor_jaccard_similarity_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

  always #5 clk = ~clk;

  // Present one item from a falling edge and hold it until it is accepted.
  task send_item(logic [1:0] cmd, logic [NODE_W-1:0] node_a, logic [NODE_W-1:0] node_b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    req.cmd    = cmd;
    req.node_a = node_a;
    req.node_b = node_b;
    req_valid  = 1'b1;
    do begin
      @(posedge clk);
    end while (!req_ready);
    board.note_request(req);
    @(negedge clk);
  endtask

  // Node ids mostly come from a small cluster so that neighborhoods overlap.
  function automatic logic [NODE_W-1:0] pick_node(int span);
    if ($urandom_range(0, 9) == 0) begin
      return NODE_W'($urandom_range(0, ROWS - 1));
    end
    return NODE_W'($urandom_range(0, span));
  endfunction

  // Stimulus: directed cases first, then random traffic.
  initial begin
    int pick;
    int span;
    logic [NODE_W-1:0] first;
    rst       = 1'b1;
    req       = '0;
    req_valid = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Identity graph, self queries, self loops, duplicate edges, an unused code and a clear.
    send_item(CMD_QUERY, 6'd0, 6'd0);
    send_item(CMD_QUERY, 6'd0, 6'd63);
    send_item(CMD_ADD, 6'd0, 6'd63);
    send_item(CMD_QUERY, 6'd63, 6'd0);
    send_item(CMD_ADD, 6'd63, 6'd0);
    send_item(CMD_ADD, 6'd21, 6'd21);
    send_item(CMD_QUERY, 6'd21, 6'd21);
    send_item(CMD_ADD, 6'd0, 6'd42);
    send_item(CMD_ADD, 6'd42, 6'd63);
    send_item(CMD_QUERY, 6'd0, 6'd42);
    send_item(CMD_QUERY, 6'd42, 6'd42);
    send_item(CMD_ADD, 6'd1, 6'd2);
    send_item(CMD_QUERY, 6'd1, 6'd63);
    send_item(CMD_UNUSED, 6'd63, 6'd63);
    send_item(CMD_QUERY, 6'd0, 6'd63);
    send_item(CMD_CLEAR, 6'd63, 6'd0);
    send_item(CMD_QUERY, 6'd0, 6'd63);
    send_item(CMD_QUERY, 6'd42, 6'd42);
    // A full star makes node 0 adjacent to every node.
    for (int i = 1; i < ROWS; i++) begin
      send_item(CMD_ADD, 6'd0, NODE_W'(i));
    end
    send_item(CMD_QUERY, 6'd0, 6'd0);
    send_item(CMD_QUERY, 6'd0, 6'd17);
    send_item(CMD_UNUSED, 6'd0, 6'd0);

    // Random traffic over clusters of varying size; clears start new clusters.
    span = 7;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_item(CMD_ADD, pick_node(span), pick_node(span));
      end else if (pick < 92) begin
        first = pick_node(span);
        send_item(CMD_QUERY, first, ($urandom_range(0, 7) == 0) ? first : pick_node(span));
      end else if (pick < 96) begin
        send_item(CMD_CLEAR, pick_node(ROWS - 1), pick_node(ROWS - 1));
        case ($urandom_range(0, 3))
          0: span = 3;
          1: span = 7;
          2: span = 15;
          default: span = ROWS - 1;
        endcase
      end else begin
        send_item(CMD_UNUSED, pick_node(ROWS - 1), pick_node(ROWS - 1));
      end
    end
    req_valid = 1'b0;

    // Drain the remaining results, then let the block settle.
    while (board.expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: stall in random bursts, never once the run turns calm.
  initial begin
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) begin
      @(negedge clk);
    end
    rsp_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        rsp_ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        rsp_ready = 1'b1;
      end
    end
  end

  // Check each delivered result.
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      board.check_response(rsp);
    end
  end

  // Watchdog: too long without any item moving ends the run.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/njs_pkg.sv
rtl/njs_ctrl.sv
rtl/njs_dp.sv
rtl/neighbor_jaccard_similarity_unit.sv
tb/testbench.sv
